/* design/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define ASSERT_SAME(label, clk, rst, ant, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked during reset too
`define ASSERT_NEXT(label, clk, ant, cons) \
   label: assert property (@(posedge clk) (ant) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/pjrq_pkg.sv */
// ----------------------------------------------------------------------------
// pjrq_pkg
// Shared constants, types and helpers of the priority job ring queue.
// ----------------------------------------------------------------------------
package pjrq_pkg;

   localparam int RING_DEPTH = 64;
   localparam int NUM_RINGS  = 4;
   localparam int PTR_W      = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
   localparam int RING_W     = 2;
   localparam int ADDR_W     = RING_W + PTR_W;
   localparam int MEM_DEPTH  = NUM_RINGS << PTR_W;
   localparam int HANDLE_W   = 32;
   localparam int FUNC_W     = 32;
   localparam int ARG_W      = 64;
   localparam int ENTRY_W    = HANDLE_W + FUNC_W + ARG_W;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_POP   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_QUERY,
      OP_NONE
   } op_type;

   // Classified command handed from the front to the back
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [RING_W-1:0]   prio;
      logic [FUNC_W-1:0]   func;
      logic [ARG_W-1:0]    arg;
      logic [HANDLE_W-1:0] qh;
   } cmd_type;

   // Ring slot increment with wrap at the ring depth
   function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

endpackage

/* design/pjrq_front.sv */
// ----------------------------------------------------------------------------
// pjrq_front
// Accepts request transactions, decodes the mode and queues the commands.
// ----------------------------------------------------------------------------
module pjrq_front
   import pjrq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [RING_W-1:0]   req_priority_req,
   input  logic [FUNC_W-1:0]   req_job_function,
   input  logic [ARG_W-1:0]    req_job_argument,
   input  logic [HANDLE_W-1:0] req_query_handle,
   output cmd_type             cmd,
   input  logic                cmd_take
);

   localparam int QDEPTH = 2;

   cmd_type    q_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   op_type     op_dec;
   logic       push;
   logic       pop;

   // Mode decode
   always_comb begin
      unique case (req_mode)
         MODE_PUSH:  op_dec = OP_PUSH;
         MODE_POP:   op_dec = OP_POP;
         MODE_QUERY: op_dec = OP_QUERY;
         default:    op_dec = OP_NONE;
      endcase
   end

   assign busy = (cnt_ff == 2'(QDEPTH));
   assign push = start && !busy;
   assign pop  = cmd_take && (cnt_ff != 2'd0);

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{valid: 1'b1, op: op_dec, prio: req_priority_req,
                              func: req_job_function, arg: req_job_argument,
                              qh: req_query_handle};
      end
   end

   always_comb begin
      cmd       = q_ff[rd_ptr_ff];
      cmd.valid = (cnt_ff != 2'd0);
   end

endmodule

/* design/pjrq_back.sv */
// ----------------------------------------------------------------------------
// pjrq_back
// Executes queued commands against the four rings and drives the responses.
// ----------------------------------------------------------------------------
module pjrq_back
   import pjrq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output logic                cmd_take,
   output logic                rsp_valid,
   output logic                rsp_accepted,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic [FUNC_W-1:0]   rsp_out_function,
   output logic [ARG_W-1:0]    rsp_out_argument,
   output logic [RING_W-1:0]   rsp_ring_used,
   output logic                rsp_complete
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SCAN,
      ST_CHECK
   } state_type;

   state_type           state_ff;
   logic [PTR_W-1:0]    head_ff [NUM_RINGS];
   logic [PTR_W-1:0]    tail_ff [NUM_RINGS];
   logic [HANDLE_W-1:0] nh_ff, nh_in;
   logic [HANDLE_W-1:0] qh_ff;
   logic [RING_W-1:0]   pop_ring_ff;
   logic [RING_W-1:0]   scan_ring_ff;
   logic [PTR_W-1:0]    scan_idx_ff;
   logic [ENTRY_W-1:0]  mem [MEM_DEPTH];
   logic [ENTRY_W-1:0]  rdata_ff;

   logic                rsp_valid_ff, rsp_accepted_ff, rsp_complete_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [FUNC_W-1:0]   rsp_function_ff;
   logic [ARG_W-1:0]    rsp_argument_ff;
   logic [RING_W-1:0]   rsp_ring_ff;

   logic [NUM_RINGS-1:0] full;
   logic [NUM_RINGS-1:0] empty;
   logic                 push_ok;
   logic [RING_W-1:0]    push_ring;
   logic                 pop_any;
   logic [RING_W-1:0]    pop_ring;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 scan_end;
   logic [RING_W-1:0]    next_ring;

   assign cmd_take = cmd.valid && (state_ff == ST_IDLE);

   // Ring occupancy
   always_comb begin
      for (int r = 0; r < NUM_RINGS; r++) begin
         full[r]  = (ptr_adv(tail_ff[r]) == head_ff[r]);
         empty[r] = (tail_ff[r] == head_ff[r]);
      end
   end

   // Push target: own ring, else first ring with room
   always_comb begin
      push_ok   = 1'b1;
      push_ring = cmd.prio;
      priority if (!full[cmd.prio]) push_ring = cmd.prio;
      else if (!full[0]) push_ring = 2'd0;
      else if (!full[1]) push_ring = 2'd1;
      else if (!full[2]) push_ring = 2'd2;
      else if (!full[3]) push_ring = 2'd3;
      else begin
         push_ok   = 1'b0;
         push_ring = 2'd0;
      end
   end

   // Pop source: lowest numbered non-empty ring
   always_comb begin
      pop_any  = 1'b1;
      pop_ring = 2'd0;
      priority if (!empty[0]) pop_ring = 2'd0;
      else if (!empty[1]) pop_ring = 2'd1;
      else if (!empty[2]) pop_ring = 2'd2;
      else if (!empty[3]) pop_ring = 2'd3;
      else pop_any = 1'b0;
   end

   // Handle counter skips zero
   always_comb begin
      nh_in = nh_ff + HANDLE_W'(1);
      if (nh_in == '0) begin
         nh_in = HANDLE_W'(1);
      end
   end

   // Memory port control
   assign scan_end  = (scan_idx_ff == tail_ff[scan_ring_ff]);
   assign next_ring = scan_ring_ff + 2'd1;

   always_comb begin
      wr_en   = cmd_take && (cmd.op == OP_PUSH) && push_ok;
      wr_addr = {push_ring, tail_ff[push_ring]};
      rd_en   = 1'b0;
      rd_addr = {pop_ring, head_ff[pop_ring]};
      if (cmd_take && (cmd.op == OP_POP) && pop_any) begin
         rd_en = 1'b1;
      end else if ((state_ff == ST_SCAN) && !scan_end) begin
         rd_en   = 1'b1;
         rd_addr = {scan_ring_ff, scan_idx_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {nh_ff, cmd.func, cmd.arg};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Sequencer, ring pointers and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nh_ff        <= HANDLE_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_RINGS; r++) begin
            head_ff[r] <= '0;
            tail_ff[r] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_take) begin
                  rsp_accepted_ff <= 1'b0;
                  rsp_handle_ff   <= '0;
                  rsp_function_ff <= '0;
                  rsp_argument_ff <= '0;
                  rsp_ring_ff     <= '0;
                  rsp_complete_ff <= 1'b0;
                  unique case (cmd.op)
                     OP_PUSH: begin
                        nh_ff           <= nh_in;
                        rsp_valid_ff    <= 1'b1;
                        rsp_handle_ff   <= nh_ff;
                        rsp_accepted_ff <= push_ok;
                        rsp_ring_ff     <= push_ring;
                        if (push_ok) begin
                           tail_ff[push_ring] <= ptr_adv(tail_ff[push_ring]);
                        end
                     end
                     OP_POP: begin
                        if (pop_any) begin
                           head_ff[pop_ring] <= ptr_adv(head_ff[pop_ring]);
                           pop_ring_ff       <= pop_ring;
                           state_ff          <= ST_POP_WAIT;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     OP_QUERY: begin
                        qh_ff        <= cmd.qh;
                        scan_ring_ff <= 2'd0;
                        scan_idx_ff  <= head_ff[0];
                        if (cmd.qh == '0) begin
                           rsp_valid_ff    <= 1'b1;
                           rsp_complete_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_POP_WAIT: begin
               rsp_valid_ff    <= 1'b1;
               rsp_accepted_ff <= 1'b1;
               rsp_handle_ff   <= rdata_ff[ENTRY_W-1 -: HANDLE_W];
               rsp_function_ff <= rdata_ff[ARG_W +: FUNC_W];
               rsp_argument_ff <= rdata_ff[ARG_W-1:0];
               rsp_ring_ff     <= pop_ring_ff;
               state_ff        <= ST_IDLE;
            end
            ST_SCAN: begin
               if (!scan_end) begin
                  scan_idx_ff <= ptr_adv(scan_idx_ff);
                  state_ff    <= ST_CHECK;
               end else if (scan_ring_ff == 2'(NUM_RINGS - 1)) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_complete_ff <= 1'b1;
                  state_ff        <= ST_IDLE;
               end else begin
                  scan_ring_ff <= next_ring;
                  scan_idx_ff  <= head_ff[next_ring];
               end
            end
            ST_CHECK: begin
               if (rdata_ff[ENTRY_W-1 -: HANDLE_W] == qh_ff) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_complete_ff <= 1'b0;
                  state_ff        <= ST_IDLE;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_out_handle   = rsp_handle_ff;
   assign rsp_out_function = rsp_function_ff;
   assign rsp_out_argument = rsp_argument_ff;
   assign rsp_ring_used    = rsp_ring_ff;
   assign rsp_complete     = rsp_complete_ff;

endmodule

/* design/priority_job_ring_queue.sv */
// ----------------------------------------------------------------------------
// priority_job_ring_queue
// Four priority job rings with handle allocation, pop and completion query.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start with req_mode and the request fields; the transaction is
//   taken on a rising edge with start high and busy low. busy rises only
//   when the two-entry command queue is full.
//   Each transaction yields one response, shown for one cycle with
//   rsp_valid high; the receiver cannot stall it. Responses come in order.
//   A push, an unused mode or an empty pop is answered without a memory read;
//   a pop of a stored job first goes through a registered ring memory read.
//   A query scans the stored handles of rings 0..3 through the single
//   memory read port, one SCAN and one CHECK step per stored job, up to
//   the first match; handle 0 is answered as complete without a scan.
//   Push sustains one transaction every cycle while no pop or query runs.
//   Reset empties all rings, sets the next handle to 1 and clears the
//   command queue; the ring memory itself is not cleared.
// ----------------------------------------------------------------------------
module priority_job_ring_queue
   import pjrq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_mode,
   input  logic [RING_W-1:0]   req_priority_req,
   input  logic [FUNC_W-1:0]   req_job_function,
   input  logic [ARG_W-1:0]    req_job_argument,
   input  logic [HANDLE_W-1:0] req_query_handle,
   output logic                rsp_valid,
   output logic                rsp_accepted,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic [FUNC_W-1:0]   rsp_out_function,
   output logic [ARG_W-1:0]    rsp_out_argument,
   output logic [RING_W-1:0]   rsp_ring_used,
   output logic                rsp_complete
);

   cmd_type cmd;
   logic    cmd_take;

   // Accept and classify
   pjrq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_priority_req (req_priority_req),
      .req_job_function (req_job_function),
      .req_job_argument (req_job_argument),
      .req_query_handle (req_query_handle),
      .cmd              (cmd),
      .cmd_take         (cmd_take)
   );

   // Execute against the rings
   pjrq_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .rsp_valid        (rsp_valid),
      .rsp_accepted     (rsp_accepted),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_out_function (rsp_out_function),
      .rsp_out_argument (rsp_out_argument),
      .rsp_ring_used    (rsp_ring_used),
      .rsp_complete     (rsp_complete)
   );

endmodule

/* design/pjrq_checker.sv */
// ----------------------------------------------------------------------------
// pjrq_port_checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pjrq_port_checker
   import pjrq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_accepted,
   input logic [HANDLE_W-1:0] rsp_out_handle,
   input logic [FUNC_W-1:0]   rsp_out_function,
   input logic [RING_W-1:0]   rsp_ring_used,
   input logic                rsp_complete
);

   // No response in the cycle after reset
   `ASSERT_NEXT(a_rst_quiet, clock, reset, !rsp_valid)
   // A completion answer carries no job
   `ASSERT_SAME(a_cpl_clean, clock, reset, rsp_valid && rsp_complete,
      !rsp_accepted && (rsp_out_handle == '0))
   // A response that is not accepted (refused push, empty pop, query, unused mode) reports ring 0 and no function
   `ASSERT_SAME(a_rej_clean, clock, reset, rsp_valid && !rsp_accepted,
      (rsp_ring_used == '0) && (rsp_out_function == '0))
   // Handles of stored jobs are never zero
   `ASSERT_SAME(a_hdl_nz, clock, reset, rsp_valid && rsp_accepted,
      rsp_out_handle != '0)

endmodule

bind priority_job_ring_queue pjrq_port_checker u_pjrq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_accepted     (rsp_accepted),
   .rsp_out_handle   (rsp_out_handle),
   .rsp_out_function (rsp_out_function),
   .rsp_ring_used    (rsp_ring_used),
   .rsp_complete     (rsp_complete)
);
